/* rtl/gle_pkg.sv */
package gle_pkg;

  // Dictionary and code sizes.
  localparam int DictSize  = 4096;
  localparam int CodeBits  = 12;
  localparam int NextBits  = CodeBits + 1;
  localparam int WidthBits = 4;
  localparam int SymBits   = 8;
  localparam int RootBits  = 4;
  localparam int FillBits  = 5;
  localparam int AccBits   = 20;

  // Root size limits and reset value.
  localparam logic [RootBits-1:0] RootMin   = 4'd2;
  localparam logic [RootBits-1:0] RootMax   = 4'd8;
  localparam logic [RootBits-1:0] RootReset = 4'd8;

  // Queue depths.
  localparam int CqDepth  = 4;
  localparam int OutDepth = 4;

  // One code handed from the front to the packer.
  typedef struct packed {
    logic [CodeBits-1:0]  code;
    logic [WidthBits-1:0] width;
    logic                 item_end;
    logic                 eod;
  } code_ent_t;

  // One packed byte waiting at the output.
  typedef struct packed {
    logic [7:0] data;
    logic       run_last;
    logic       stream_end;
  } out_ent_t;

  // Dictionary entry: string prefix, last symbol and the next sibling.
  typedef struct packed {
    logic [CodeBits-1:0] prefix;
    logic [SymBits-1:0]  sym;
    logic [CodeBits-1:0] sib;
  } dict_ent_t;

  typedef enum logic [3:0] {
    F_IDLE, F_CLEAR, F_HEAD, F_HEADW, F_CMP, F_EMIT, F_FULL, F_EOD1, F_EOD2, F_DONE
  } front_state_e;

  typedef enum logic [1:0] {
    P_TAKE, P_BYTES
  } pack_state_e;

  // First code above the clear and end codes.
  function automatic logic [NextBits-1:0] base_of(input logic [RootBits-1:0] r);
    return (NextBits'(1) << r) + NextBits'(2);
  endfunction

endpackage

/* rtl/gle_cq.sv */
module gle_cq
  import gle_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  code_ent_t data_i,
  output logic      full_o,
  input  logic      pop_i,
  output code_ent_t data_o,
  output logic      empty_o
);

  localparam int PtrBits = $clog2(CqDepth);

  code_ent_t           mem_q [CqDepth];
  logic [PtrBits-1:0]  wr_q, rd_q;
  logic [PtrBits:0]    cnt_q;
  logic                do_push, do_pop;

  assign full_o  = (cnt_q == (PtrBits+1)'(CqDepth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Storage for queued codes.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

/* rtl/gle_front.sv */
module gle_front
  import gle_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [RootBits-1:0] cfg_wdata_i,
  input  logic                push_i,
  input  logic [SymBits-1:0]  symbol_i,
  input  logic                end_of_data_i,
  output logic                full_o,
  output logic                cq_push_o,
  output code_ent_t           cq_data_o,
  input  logic                cq_full_i
);

  localparam int AddrBits = $clog2(DictSize);

  front_state_e          state_q, state_d;
  logic [RootBits-1:0]   root_q, root_d;
  logic [NextBits-1:0]   next_q, next_d;
  logic [WidthBits-1:0]  cw_q, cw_d;
  logic [CodeBits-1:0]   prefix_q, prefix_d;
  logic                  pvalid_q, pvalid_d;
  logic                  clrpend_q, clrpend_d;
  logic [SymBits-1:0]    sym_q, sym_d;
  logic                  eod_q, eod_d;
  logic                  lookup_q, lookup_d;
  logic [CodeBits-1:0]   cand_q, cand_d;
  logic [CodeBits-1:0]   head_q, head_d;

  // Dictionary memories: entries by code, and the newest child of each code.
  dict_ent_t             ent_mem [DictSize];
  logic [CodeBits-1:0]   fc_mem [DictSize];
  dict_ent_t             ent_rd_q;
  logic [CodeBits-1:0]   fc_rd_q;
  logic                  ent_re, ent_we, fc_re, fc_we;
  logic [AddrBits-1:0]   ent_ra;

  logic [CodeBits-1:0]   clear_code;
  logic [NextBits-1:0]   base;
  logic [SymBits:0]      sym_mask;
  logic [SymBits-1:0]    sym_in;
  logic [RootBits-1:0]   root_new;
  logic [NextBits-1:0]   next_inc;

  // A code is a live dictionary entry only between base and the bound.
  function automatic logic in_range(input logic [CodeBits-1:0] c,
                                    input logic [NextBits-1:0] lo,
                                    input logic [NextBits-1:0] hi);
    return ({1'b0, c} >= lo) && ({1'b0, c} < hi);
  endfunction

  assign clear_code = CodeBits'(1) << root_q;
  assign base       = base_of(root_q);
  assign sym_mask   = ((SymBits+1)'(1) << root_q) - (SymBits+1)'(1);
  assign sym_in     = symbol_i & sym_mask[SymBits-1:0];
  assign next_inc   = next_q + NextBits'(1);
  assign full_o     = (state_q != F_IDLE);

  // Clamp a written root size into its legal range.
  always_comb begin
    if (cfg_wdata_i < RootMin) begin
      root_new = RootMin;
    end else if (cfg_wdata_i > RootMax) begin
      root_new = RootMax;
    end else begin
      root_new = cfg_wdata_i;
    end
  end

  // Dictionary memory ports.
  always_ff @(posedge clk_i) begin
    if (fc_we) begin
      fc_mem[prefix_q] <= next_q[AddrBits-1:0];
    end
    if (fc_re) begin
      fc_rd_q <= fc_mem[prefix_q];
    end
    if (ent_we) begin
      ent_mem[next_q[AddrBits-1:0]] <= '{prefix: prefix_q, sym: sym_q, sib: head_q};
    end
    if (ent_re) begin
      ent_rd_q <= ent_mem[ent_ra];
    end
  end

  // Sequencer for one symbol: clear code, child list walk, insert, final codes.
  always_comb begin
    state_d   = state_q;
    root_d    = root_q;
    next_d    = next_q;
    cw_d      = cw_q;
    prefix_d  = prefix_q;
    pvalid_d  = pvalid_q;
    clrpend_d = clrpend_q;
    sym_d     = sym_q;
    eod_d     = eod_q;
    lookup_d  = lookup_q;
    cand_d    = cand_q;
    head_d    = head_q;
    cq_push_o = 1'b0;
    cq_data_o = '{code: prefix_q, width: cw_q, item_end: 1'b0, eod: 1'b0};
    fc_re     = 1'b0;
    fc_we     = 1'b0;
    ent_re    = 1'b0;
    ent_we    = 1'b0;
    ent_ra    = fc_rd_q;

    unique case (state_q)
      F_IDLE: begin
        if (push_i) begin
          sym_d    = sym_in;
          eod_d    = end_of_data_i;
          lookup_d = pvalid_q;
          if (!pvalid_q) begin
            prefix_d = CodeBits'(sym_in);
            pvalid_d = 1'b1;
          end
          if (clrpend_q) begin
            state_d = F_CLEAR;
          end else if (pvalid_q) begin
            state_d = F_HEAD;
          end else begin
            state_d = F_EOD1;
          end
        end
      end
      F_CLEAR: begin
        if (!cq_full_i) begin
          cq_push_o      = 1'b1;
          cq_data_o.code = clear_code;
          clrpend_d      = 1'b0;
          state_d        = lookup_q ? F_HEAD : F_EOD1;
        end
      end
      F_HEAD: begin
        fc_re   = 1'b1;
        state_d = F_HEADW;
      end
      F_HEADW: begin
        head_d = fc_rd_q;
        if (in_range(fc_rd_q, base, next_q)) begin
          ent_re  = 1'b1;
          ent_ra  = fc_rd_q;
          cand_d  = fc_rd_q;
          state_d = F_CMP;
        end else begin
          state_d = F_EMIT;
        end
      end
      F_CMP: begin
        if (ent_rd_q.prefix == prefix_q) begin
          if (ent_rd_q.sym == sym_q) begin
            prefix_d = cand_q;
            state_d  = F_EOD1;
          end else if (in_range(ent_rd_q.sib, base, {1'b0, cand_q})) begin
            ent_re = 1'b1;
            ent_ra = ent_rd_q.sib;
            cand_d = ent_rd_q.sib;
          end else begin
            state_d = F_EMIT;
          end
        end else begin
          state_d = F_EMIT;
        end
      end
      F_EMIT: begin
        if (!cq_full_i) begin
          cq_push_o = 1'b1;
          if (next_q >= NextBits'(DictSize)) begin
            state_d = F_FULL;
          end else begin
            ent_we   = 1'b1;
            fc_we    = 1'b1;
            next_d   = next_inc;
            if (next_inc > (NextBits'(1) << cw_q)) begin
              cw_d = cw_q + WidthBits'(1);
            end
            prefix_d = CodeBits'(sym_q);
            state_d  = F_EOD1;
          end
        end
      end
      F_FULL: begin
        if (!cq_full_i) begin
          cq_push_o      = 1'b1;
          cq_data_o.code = clear_code;
          next_d         = base;
          cw_d           = root_q + WidthBits'(1);
          prefix_d       = CodeBits'(sym_q);
          state_d        = F_EOD1;
        end
      end
      F_EOD1: begin
        if (!eod_q) begin
          state_d = F_DONE;
        end else if (!cq_full_i) begin
          cq_push_o = 1'b1;
          state_d   = F_EOD2;
        end
      end
      F_EOD2: begin
        if (!cq_full_i) begin
          cq_push_o      = 1'b1;
          cq_data_o.code = clear_code + CodeBits'(1);
          state_d        = F_DONE;
        end
      end
      F_DONE: begin
        if (!cq_full_i) begin
          cq_push_o = 1'b1;
          cq_data_o = '{code: '0, width: '0, item_end: 1'b1, eod: eod_q};
          if (eod_q) begin
            next_d    = base;
            cw_d      = root_q + WidthBits'(1);
            prefix_d  = '0;
            pvalid_d  = 1'b0;
            clrpend_d = 1'b1;
          end
          state_d = F_IDLE;
        end
      end
      default: begin
        state_d = F_IDLE;
      end
    endcase

    // A register write restarts the stream with the new root size.
    if (cfg_we_i) begin
      root_d    = root_new;
      next_d    = base_of(root_new);
      cw_d      = root_new + WidthBits'(1);
      prefix_d  = '0;
      pvalid_d  = 1'b0;
      clrpend_d = 1'b1;
    end
  end

  // Control and stream state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= F_IDLE;
      root_q    <= RootReset;
      next_q    <= base_of(RootReset);
      cw_q      <= RootReset + WidthBits'(1);
      prefix_q  <= '0;
      pvalid_q  <= 1'b0;
      clrpend_q <= 1'b1;
      eod_q     <= 1'b0;
      lookup_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      root_q    <= root_d;
      next_q    <= next_d;
      cw_q      <= cw_d;
      prefix_q  <= prefix_d;
      pvalid_q  <= pvalid_d;
      clrpend_q <= clrpend_d;
      eod_q     <= eod_d;
      lookup_q  <= lookup_d;
    end
  end

  // Item payload and walk pointers.
  always_ff @(posedge clk_i) begin
    sym_q  <= sym_d;
    cand_q <= cand_d;
    head_q <= head_d;
  end

endmodule

/* rtl/gle_pack.sv */
module gle_pack
  import gle_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       restart_i,
  input  code_ent_t  cq_data_i,
  input  logic       cq_empty_i,
  output logic       cq_pop_o,
  output logic [7:0] out_byte_o,
  output logic       run_last_o,
  output logic       stream_end_o,
  output logic       empty,
  input  logic       pop
);

  localparam int PtrBits = $clog2(OutDepth);

  pack_state_e          state_q, state_d;
  logic [AccBits-1:0]   acc_q, acc_d;
  logic [FillBits-1:0]  fill_q, fill_d;
  logic                 end_q, end_d;
  logic                 eod_q, eod_d;
  logic                 hold_v_q, hold_v_d;
  logic [7:0]           hold_q, hold_d;

  out_ent_t             of_mem_q [OutDepth];
  logic [PtrBits-1:0]   of_wr_q, of_rd_q;
  logic [PtrBits:0]     of_cnt_q;
  logic                 of_full, of_push, of_pop;
  out_ent_t             of_data;

  logic [NextBits-1:0]  mask;
  logic [CodeBits-1:0]  code_m;
  logic                 byte_go;

  assign mask    = (NextBits'(1) << cq_data_i.width) - NextBits'(1);
  assign code_m  = cq_data_i.code & mask[CodeBits-1:0];
  assign byte_go = !hold_v_q || !of_full;

  // Bit packing: one byte per cycle when the output queue has room; the
  // newest byte waits until the next one or the item's end sets run_last.
  always_comb begin
    state_d  = state_q;
    acc_d    = acc_q;
    fill_d   = fill_q;
    end_d    = end_q;
    eod_d    = eod_q;
    hold_v_d = hold_v_q;
    hold_d   = hold_q;
    cq_pop_o = 1'b0;
    of_push  = 1'b0;
    of_data  = '{data: hold_q, run_last: 1'b0, stream_end: 1'b0};

    unique case (state_q)
      P_TAKE: begin
        if (!cq_empty_i) begin
          cq_pop_o = 1'b1;
          acc_d    = acc_q | (AccBits'(code_m) << fill_q[2:0]);
          fill_d   = fill_q + FillBits'(cq_data_i.width);
          end_d    = cq_data_i.item_end;
          eod_d    = cq_data_i.eod;
          state_d  = P_BYTES;
        end
      end
      P_BYTES: begin
        if (fill_q >= FillBits'(8) || (end_q && eod_q && fill_q != '0)) begin
          if (byte_go) begin
            of_push  = hold_v_q;
            hold_d   = acc_q[7:0];
            hold_v_d = 1'b1;
            acc_d    = acc_q >> 8;
            fill_d   = (fill_q >= FillBits'(8)) ? fill_q - FillBits'(8) : '0;
          end
        end else if (end_q) begin
          if (!of_full) begin
            of_push  = hold_v_q;
            of_data  = '{data: hold_q, run_last: 1'b1, stream_end: eod_q};
            hold_v_d = 1'b0;
            state_d  = P_TAKE;
          end
        end else begin
          state_d = P_TAKE;
        end
      end
      default: begin
        state_d = P_TAKE;
      end
    endcase

    if (restart_i) begin
      acc_d  = '0;
      fill_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= P_TAKE;
      acc_q    <= '0;
      fill_q   <= '0;
      end_q    <= 1'b0;
      eod_q    <= 1'b0;
      hold_v_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      acc_q    <= acc_d;
      fill_q   <= fill_d;
      end_q    <= end_d;
      eod_q    <= eod_d;
      hold_v_q <= hold_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hold_q <= hold_d;
  end

  // Output queue of finished bytes.
  assign of_full      = (of_cnt_q == (PtrBits+1)'(OutDepth));
  assign empty        = (of_cnt_q == '0);
  assign of_pop       = pop && !empty;
  assign out_byte_o   = of_mem_q[of_rd_q].data;
  assign run_last_o   = of_mem_q[of_rd_q].run_last;
  assign stream_end_o = of_mem_q[of_rd_q].stream_end;

  always_ff @(posedge clk_i) begin
    if (of_push) begin
      of_mem_q[of_wr_q] <= of_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      of_wr_q  <= '0;
      of_rd_q  <= '0;
      of_cnt_q <= '0;
    end else begin
      if (of_push) begin
        of_wr_q <= of_wr_q + 1'b1;
      end
      if (of_pop) begin
        of_rd_q <= of_rd_q + 1'b1;
      end
      if (of_push && !of_pop) begin
        of_cnt_q <= of_cnt_q + 1'b1;
      end else if (of_pop && !of_push) begin
        of_cnt_q <= of_cnt_q - 1'b1;
      end
    end
  end

endmodule

/* rtl/gif_lzw_encoder.sv */
// GIF-style LZW encoder with variable code width up to 12 bits, packed LSB
// first into bytes. Symbols go in through push/full and packed bytes come out
// through empty/pop; run_last flags the last byte caused by a symbol and
// stream_end the last byte of a stream, which ends with the end-of-data
// symbol. The front takes one symbol at a time and walks the child list of
// the current prefix in the dictionary memory. A symbol that needs a lookup
// visits the entries of that list, one registered memory read and compare
// each, at most 2^root_bits of them, and a new entry is written when the
// string is not found. The clear code, a full dictionary and the end code
// each push one more code, and the front stalls while the code queue is
// full. The packer runs behind a 4-entry code queue and writes one byte per
// cycle into a 4-entry output queue while that queue has room. Writing
// cfg_wdata_i (root_bits, clamped to 2..8) restarts the stream and must
// happen only while the block is idle.
module gif_lzw_encoder
  import gle_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [RootBits-1:0] cfg_wdata_i,
  input  logic                push,
  output logic                full,
  input  logic [SymBits-1:0]  symbol_i,
  input  logic                end_of_data_i,
  output logic                empty,
  input  logic                pop,
  output logic [7:0]          out_byte_o,
  output logic                run_last_o,
  output logic                stream_end_o
);

  code_ent_t cq_in, cq_out;
  logic      cq_push, cq_full, cq_pop, cq_empty;

  gle_front u_front (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_wdata_i,
    .push_i        (push),
    .symbol_i,
    .end_of_data_i,
    .full_o        (full),
    .cq_push_o     (cq_push),
    .cq_data_o     (cq_in),
    .cq_full_i     (cq_full)
  );

  gle_cq u_cq (
    .clk_i,
    .rst_ni,
    .push_i  (cq_push),
    .data_i  (cq_in),
    .full_o  (cq_full),
    .pop_i   (cq_pop),
    .data_o  (cq_out),
    .empty_o (cq_empty)
  );

  gle_pack u_pack (
    .clk_i,
    .rst_ni,
    .restart_i    (cfg_we_i),
    .cq_data_i    (cq_out),
    .cq_empty_i   (cq_empty),
    .cq_pop_o     (cq_pop),
    .out_byte_o,
    .run_last_o,
    .stream_end_o,
    .empty,
    .pop
  );

endmodule

/* rtl/gle_checker.sv */
module gle_checker
  import gle_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                push,
  input logic                full,
  input logic                empty,
  input logic                pop,
  input logic [7:0]          out_byte_o,
  input logic                run_last_o,
  input logic                stream_end_o
);

  // The last byte of a stream also closes the transaction that caused it.
  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && stream_end_o) |-> run_last_o)
    else $error("stream_end without run_last");

  // An accepted symbol keeps the input side busy on the next cycle.
  a_busy_after_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !full) |=> full)
    else $error("input not busy after an accepted symbol");

  // A waiting byte stays put until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_byte_o)))
    else $error("waiting output byte changed");

endmodule

bind gif_lzw_encoder gle_checker u_gle_checker (.*);

/* tb/gif_lzw_encoder_tb.sv */
module gif_lzw_encoder_tb
  import gle_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  // Expected output byte with its flags.
  typedef struct packed {
    logic [7:0] data;
    logic       run_last;
    logic       stream_end;
  } lzw_byte_t;

  // One row of the directed stimulus: a register write or a symbol.
  typedef struct {
    bit         is_cfg;
    logic [3:0] cfg_val;
    logic [7:0] sym;
    bit         eod;
    bit         has_exp;
    int         n_exp;
    lzw_byte_t  exp_bytes [4];
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [RootBits-1:0] cfg_wdata_i = '0;
  logic push = 1'b0;
  logic full;
  logic [SymBits-1:0] symbol_i = '0;
  logic end_of_data_i = 1'b0;
  logic empty;
  logic pop = 1'b0;
  logic [7:0] out_byte_o;
  logic run_last_o;
  logic stream_end_o;

  // Predictor state for the encoder.
  logic [11:0] enc_dict_prefix [DictSize];
  logic [7:0]  enc_dict_sym [DictSize];
  int unsigned enc_root;
  int unsigned enc_next;
  int unsigned enc_width;
  int unsigned enc_prefix;
  bit          enc_prefix_valid;
  int unsigned enc_acc;
  int unsigned enc_fill;
  bit          enc_clear_pending;

  lzw_byte_t   byte_queue [$];
  lzw_byte_t   step_bytes [$];
  int          error_count = 0;
  bit          no_idle = 1'b0;
  bit          stim_done = 1'b0;

  gif_lzw_encoder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .push          (push),
    .full          (full),
    .symbol_i      (symbol_i),
    .end_of_data_i (end_of_data_i),
    .empty         (empty),
    .pop           (pop),
    .out_byte_o    (out_byte_o),
    .run_last_o    (run_last_o),
    .stream_end_o  (stream_end_o)
  );

  always #10 clk_i = ~clk_i;

  // Restart the predicted stream with the current root size.
  function automatic void restart_stream();
    enc_next = (1 << enc_root) + 2;
    enc_width = enc_root + 1;
    enc_prefix = 0;
    enc_prefix_valid = 1'b0;
    enc_acc = 0;
    enc_fill = 0;
    enc_clear_pending = 1'b1;
  endfunction

  function automatic void set_root(input logic [3:0] value);
    int unsigned v;
    v = value;
    if (v < 2) v = 2;
    if (v > 8) v = 8;
    enc_root = v;
    restart_stream();
  endfunction

  // Pack one code LSB first, collecting any completed bytes.
  function automatic void pack_code(input int unsigned code);
    int unsigned w;
    int unsigned acc;
    int unsigned fill;
    lzw_byte_t b;
    w = (enc_width > CodeBits) ? CodeBits : enc_width;
    acc = enc_acc | ((code & ((1 << w) - 1)) << enc_fill);
    fill = enc_fill + w;
    while (fill >= 8) begin
      b.data = acc[7:0];
      b.run_last = 1'b0;
      b.stream_end = 1'b0;
      step_bytes.push_back(b);
      acc = acc >> 8;
      fill -= 8;
    end
    enc_acc = acc & 8'hFF;
    enc_fill = fill;
  endfunction

  // Work out the bytes one symbol causes and queue them as expectations.
  function automatic void encode_symbol(input logic [7:0] sym_in, input bit eod);
    int unsigned clear_code;
    int unsigned base;
    int unsigned sym;
    bit found;
    lzw_byte_t b;
    clear_code = 1 << enc_root;
    base = clear_code + 2;
    sym = sym_in & (clear_code - 1);
    found = 1'b0;
    step_bytes.delete();
    if (enc_clear_pending) begin
      pack_code(clear_code);
      enc_clear_pending = 1'b0;
    end
    if (!enc_prefix_valid) begin
      enc_prefix = sym;
      enc_prefix_valid = 1'b1;
    end else begin
      for (int unsigned i = base; i < enc_next && i < DictSize; i++) begin
        if (!found && enc_dict_prefix[i] == enc_prefix && enc_dict_sym[i] == sym) begin
          enc_prefix = i;
          found = 1'b1;
        end
      end
      if (!found) begin
        pack_code(enc_prefix);
        if (enc_next >= DictSize) begin
          pack_code(clear_code);
          enc_next = base;
          enc_width = enc_root + 1;
        end else begin
          enc_dict_prefix[enc_next] = enc_prefix[11:0];
          enc_dict_sym[enc_next] = sym[7:0];
          enc_next++;
          if (enc_width < 15 && enc_next > (1 << enc_width)) enc_width++;
        end
        enc_prefix = sym;
      end
    end
    if (eod) begin
      pack_code(enc_prefix);
      pack_code(clear_code + 1);
      if (enc_fill != 0) begin
        b.data = enc_acc[7:0];
        b.run_last = 1'b0;
        b.stream_end = 1'b0;
        step_bytes.push_back(b);
      end
      if (step_bytes.size() > 0) step_bytes[$].stream_end = 1'b1;
      restart_stream();
    end
    if (step_bytes.size() > 0) step_bytes[$].run_last = 1'b1;
    foreach (step_bytes[k]) byte_queue.push_back(step_bytes[k]);
  endfunction

  // Present one symbol and hold it until the transaction completes.
  task automatic send_symbol(input logic [7:0] sym, input bit eod);
    if (!no_idle && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    push <= 1'b1;
    symbol_i <= sym;
    end_of_data_i <= eod;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    encode_symbol(sym, eod);
  endtask

  task automatic drop_push();
    push <= 1'b0;
    @(posedge clk_i);
  endtask

  // Wait until the block has drained, then let its pipeline settle.
  task automatic wait_drained();
    int guard;
    guard = 0;
    while (byte_queue.size() != 0 && guard < 200000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (2200) @(posedge clk_i);
  endtask

  task automatic write_root(input logic [3:0] value);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    set_root(value);
    @(posedge clk_i);
  endtask

  // Result side: pop with random stalls and compare against expectations.
  always @(posedge clk_i) begin
    lzw_byte_t want;
    if (rst_ni) begin
      if (pop && !empty) begin
        if (byte_queue.size() == 0) begin
          $error("Unexpected output byte %02h", out_byte_o);
          error_count++;
        end else begin
          want = byte_queue.pop_front();
          if (out_byte_o !== want.data) begin
            $error("out_byte expected %02h actual %02h", want.data, out_byte_o);
            error_count++;
          end
          if (run_last_o !== want.run_last) begin
            $error("run_last expected %0b actual %0b", want.run_last, run_last_o);
            error_count++;
          end
          if (stream_end_o !== want.stream_end) begin
            $error("stream_end expected %0b actual %0b", want.stream_end, stream_end_o);
            error_count++;
          end
        end
      end
    end
  end

  // Pop stalls come in bursts until the final part of the run.
  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      if (!no_idle && $urandom_range(0, 7) == 0) begin
        stall = $urandom_range(1, 13);
        pop <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      pop <= 1'b1;
      @(posedge clk_i);
    end
  end

  // Main stimulus.
  initial begin
    stim_row_t rows [$];
    stim_row_t r;
    int n_items;
    int len;
    int root_choices [5];
    logic [7:0] pool [$];
    logic [7:0] s;
    lzw_byte_t e;

    root_choices = '{2, 8, 3, 5, 7};
    set_root(RootReset);
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows. A lone symbol with end of data at root 8 after reset
    // packs the clear code, the symbol and the end code in 9-bit codes:
    // 0x100, 0x000, 0x101 give 00 01 04 04.
    r = '{default: 0};
    r.sym = 8'h00; r.eod = 1; r.has_exp = 1; r.n_exp = 4;
    r.exp_bytes[0] = {8'h00, 1'b0, 1'b0};
    r.exp_bytes[1] = {8'h01, 1'b0, 1'b0};
    r.exp_bytes[2] = {8'h04, 1'b0, 1'b0};
    r.exp_bytes[3] = {8'h04, 1'b1, 1'b1};
    rows.push_back(r);
    r = '{default: 0};
    r.sym = 8'hFF; rows.push_back(r);
    r.sym = 8'hFF; rows.push_back(r);
    r.sym = 8'hFF; rows.push_back(r);
    r.sym = 8'h00; rows.push_back(r);
    r.sym = 8'hFF; r.eod = 1; rows.push_back(r);
    // Root below range clamps to 2; wide symbols are masked.
    r = '{default: 0}; r.is_cfg = 1; r.cfg_val = 4'd0; rows.push_back(r);
    r = '{default: 0};
    for (int i = 0; i < 10; i++) begin
      r.sym = 8'(8'hFC | (i % 3));
      rows.push_back(r);
    end
    r.sym = 8'h03; r.eod = 1; rows.push_back(r);
    // Root above range clamps to 8.
    r = '{default: 0}; r.is_cfg = 1; r.cfg_val = 4'hF; rows.push_back(r);
    r = '{default: 0}; r.sym = 8'hA5; rows.push_back(r);
    r.sym = 8'h5A; r.eod = 1; rows.push_back(r);
    r = '{default: 0}; r.is_cfg = 1; r.cfg_val = 4'd1; rows.push_back(r);

    foreach (rows[i]) begin
      if (rows[i].is_cfg) begin
        drop_push();
        wait_drained();
        write_root(rows[i].cfg_val);
      end else begin
        send_symbol(rows[i].sym, rows[i].eod);
        if (rows[i].has_exp) begin
          if (byte_queue.size() != rows[i].n_exp) begin
            $error("byte count expected %0d actual %0d", rows[i].n_exp, byte_queue.size());
            error_count++;
          end else begin
            for (int k = 0; k < rows[i].n_exp; k++) begin
              e = rows[i].exp_bytes[k];
              if (byte_queue[k] !== e) begin
                $error("out_byte expected %02h actual %02h", e.data, byte_queue[k].data);
                error_count++;
              end
            end
          end
        end
      end
    end

    // Hold off until every expected byte has arrived.
    drop_push();
    wait_drained();

    // Random part: streams over small alphabets so strings repeat.
    n_items = 0;
    for (int phase = 0; phase < 5; phase++) begin
      drop_push();
      wait_drained();
      write_root(4'(root_choices[phase]));
      while (n_items < 26 * (phase + 1)) begin
        len = $urandom_range(1, 25);
        pool.delete();
        for (int k = 0; k < 3; k++) pool.push_back(8'($urandom_range(0, 255)));
        if (phase == 4) no_idle = 1'b1;
        for (int k = 0; k < len; k++) begin
          s = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                           : pool[$urandom_range(0, 2)];
          send_symbol(s, k == len - 1);
          n_items++;
        end
      end
    end

    drop_push();
    stim_done = 1'b1;
    wait_drained();

    if (error_count == 0 && byte_queue.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      if (byte_queue.size() != 0) $error("%0d expected bytes never came", byte_queue.size());
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #400ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
